// ===== sv/sccp_pkg.sv =====
// ----------------------------------------------------------------------------
// sccp_pkg
// Shared types, widths and the DC luminance prefix table for the packer.
// ----------------------------------------------------------------------------
`default_nettype none

package sccp_pkg;

    localparam int DEFAULT_WORD_BITS = 32;
    localparam int VALUE_W           = 10;
    localparam int SIZE_W            = 4;
    localparam int CODE_W            = 16;
    localparam int LEN_W             = 5;
    localparam int NUM_SIZES         = 10;

    localparam logic [6:0] PREFIX_CODE [NUM_SIZES] = '{
        7'd0, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd14, 7'd30, 7'd62, 7'd126
    };

    localparam logic [2:0] PREFIX_LEN [NUM_SIZES] = '{
        3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7
    };

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              last;
    } enc_t;

endpackage

`default_nettype wire

// ===== sv/sccp_if.sv =====
// ----------------------------------------------------------------------------
// sccp_if
// Request channels: coefficient input and packed word output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sccp_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [sccp_pkg::VALUE_W-1:0] value;
    logic                           last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface sccp_out_if #(
    parameter int WORD_BITS = sccp_pkg::DEFAULT_WORD_BITS
);
    localparam int VB_W = $clog2(WORD_BITS + 1);

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] word;
    logic [VB_W-1:0]      valid_bits;
    logic                 final_word;

    modport source (output valid, output word, output valid_bits, output final_word,
                    input ready);
    modport sink   (input valid, input word, input valid_bits, input final_word,
                    output ready);
endinterface

`default_nettype wire

// ===== sv/size_category_code_packer.sv =====
// ----------------------------------------------------------------------------
// size_category_code_packer
// Size-category prefix coder and MSB-first word packer.
// ----------------------------------------------------------------------------
// Usage:
//   coef   : one signed coefficient per request, with last marking the end
//            of a stream.
//   stream : packed words, WORD_BITS bits each, MSB first; on last the
//            remaining partial word is flushed right-aligned with its bit
//            count and final_word set.
//   One coefficient is accepted every cycle while the output queue has room.
//   A word passes through the code register and the output queue to stream.
//   A coefficient that both fills a word and flushes a partial one yields
//   two words, drained one per cycle while stream is ready from a four-entry
//   output queue; coef is accepted while that queue has room for two words.
//   When stream stalls, the queue fills and then coef.ready drops; nothing
//   is lost. Reset empties the queue and the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module size_category_code_packer #(
    parameter int WORD_BITS = sccp_pkg::DEFAULT_WORD_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sccp_in_if.sink    coef,
    sccp_out_if.source stream
);

    localparam int VB_W  = $clog2(WORD_BITS + 1);
    localparam int RES_W = WORD_BITS + VB_W + 1;

    sccp_pkg::enc_t   enc;
    logic             room;
    logic             push0;
    logic             push1;
    logic [RES_W-1:0] data0;
    logic [RES_W-1:0] data1;
    logic [RES_W-1:0] dout;

    sccp_encoder u_encoder (
        .value (coef.value),
        .last  (coef.last),
        .enc   (enc)
    );

    sccp_packer #(
        .WORD_BITS (WORD_BITS),
        .VB_W      (VB_W),
        .RES_W     (RES_W)
    ) u_packer (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (coef.valid),
        .enc_ready (coef.ready),
        .enc       (enc),
        .room      (room),
        .push0     (push0),
        .push1     (push1),
        .data0     (data0),
        .data1     (data1)
    );

    sccp_res_fifo #(
        .DATA_W (RES_W)
    ) u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push0      (push0),
        .push1      (push1),
        .data0      (data0),
        .data1      (data1),
        .room       (room),
        .dout_valid (stream.valid),
        .dout_ready (stream.ready),
        .dout       (dout)
    );

    assign stream.word       = dout[RES_W-1 -: WORD_BITS];
    assign stream.valid_bits = dout[VB_W:1];
    assign stream.final_word = dout[0];

endmodule

`default_nettype wire

// ===== sv/sccp_encoder.sv =====
// ----------------------------------------------------------------------------
// sccp_encoder
// Size category, prefix and magnitude bits of one coefficient.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_encoder (
    input  wire logic signed [sccp_pkg::VALUE_W-1:0] value,
    input  wire logic                                last,
    output sccp_pkg::enc_t                           enc
);

    logic [sccp_pkg::VALUE_W-1:0] neg_mag;
    logic [sccp_pkg::VALUE_W-2:0] mag;
    logic [sccp_pkg::SIZE_W-1:0]  size;
    logic [sccp_pkg::VALUE_W-2:0] size_mask;
    logic [sccp_pkg::VALUE_W-2:0] mag_bits;
    logic [sccp_pkg::CODE_W-1:0]  prefix;

    always_comb
    begin
        neg_mag = ~value + sccp_pkg::VALUE_W'(1);
        if (!value[sccp_pkg::VALUE_W-1])
        begin
            mag = value[sccp_pkg::VALUE_W-2:0];
        end
        else if (neg_mag[sccp_pkg::VALUE_W-1])
        begin
            // most negative pattern: saturate
            mag = '1;
        end
        else
        begin
            mag = neg_mag[sccp_pkg::VALUE_W-2:0];
        end

        size = '0;
        for (int i = 0; i < sccp_pkg::VALUE_W - 1; i++)
        begin
            if (mag[i])
            begin
                size = sccp_pkg::SIZE_W'(i + 1);
            end
        end

        size_mask = ~({(sccp_pkg::VALUE_W-1){1'b1}} << size);
        mag_bits  = value[sccp_pkg::VALUE_W-1] ? (~mag & size_mask) : mag;

        prefix   = sccp_pkg::CODE_W'(sccp_pkg::PREFIX_CODE[size]) << size;
        enc.code = prefix | sccp_pkg::CODE_W'(mag_bits);
        enc.len  = sccp_pkg::LEN_W'(sccp_pkg::PREFIX_LEN[size]) + sccp_pkg::LEN_W'(size);
        enc.last = last;
    end

endmodule

`default_nettype wire

// ===== sv/sccp_packer.sv =====
// ----------------------------------------------------------------------------
// sccp_packer
// Code register and bit accumulator; forms up to two words per code.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_packer #(
    parameter int WORD_BITS = sccp_pkg::DEFAULT_WORD_BITS,
    parameter int VB_W      = $clog2(WORD_BITS + 1),
    parameter int RES_W     = WORD_BITS + VB_W + 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           enc_valid,
    output logic                enc_ready,
    input  wire sccp_pkg::enc_t enc,
    input  wire logic           room,
    output logic                push0,
    output logic                push1,
    output logic [RES_W-1:0]    data0,
    output logic [RES_W-1:0]    data1
);

    localparam int CW = WORD_BITS + sccp_pkg::CODE_W;
    localparam int FW = $clog2(WORD_BITS);
    localparam int TW = $clog2(2 * WORD_BITS);

    logic                 a_valid_reg;
    sccp_pkg::enc_t       a_reg;
    logic [WORD_BITS-1:0] acc_reg;
    logic [WORD_BITS-1:0] acc_next;
    logic [FW-1:0]        fill_reg;
    logic [FW-1:0]        fill_next;

    logic                 advance;
    logic [CW-1:0]        comb;
    logic [TW-1:0]        total;
    logic [TW-1:0]        rest;
    logic                 full;
    logic [WORD_BITS-1:0] word_full;
    logic [WORD_BITS-1:0] acc_after;
    logic [FW-1:0]        fill_after;
    logic                 has_part;
    logic [RES_W-1:0]     res_full;
    logic [RES_W-1:0]     res_part;

    assign advance   = a_valid_reg && room;
    assign enc_ready = !a_valid_reg || room;

    always_comb
    begin
        comb  = (CW'(acc_reg) << a_reg.len) | CW'(a_reg.code);
        total = TW'(fill_reg) + TW'(a_reg.len);
        full  = total >= TW'(WORD_BITS);
        rest  = total - TW'(WORD_BITS);
        word_full = WORD_BITS'(comb >> rest);

        if (full)
        begin
            acc_after  = WORD_BITS'(comb & ((CW'(1) << rest) - CW'(1)));
            fill_after = FW'(rest);
        end
        else
        begin
            acc_after  = WORD_BITS'(comb);
            fill_after = FW'(total);
        end

        has_part = a_reg.last && (fill_after != '0);
        res_full = {word_full, VB_W'(WORD_BITS), a_reg.last && (rest == '0)};
        res_part = {acc_after, VB_W'(fill_after), 1'b1};

        push0 = advance && (full || has_part);
        push1 = advance && full && has_part;
        data0 = full ? res_full : res_part;
        data1 = res_part;

        if (a_reg.last)
        begin
            acc_next  = '0;
            fill_next = '0;
        end
        else
        begin
            acc_next  = acc_after;
            fill_next = fill_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            acc_reg     <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (enc_ready)
            begin
                a_valid_reg <= enc_valid;
            end
            if (advance)
            begin
                acc_reg  <= acc_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enc_ready && enc_valid)
        begin
            a_reg <= enc;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sccp_res_fifo.sv =====
// ----------------------------------------------------------------------------
// sccp_res_fifo
// Four-entry result queue taking up to two words per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sccp_res_fifo #(
    parameter int DATA_W = 39
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push0,
    input  wire logic              push1,
    input  wire logic [DATA_W-1:0] data0,
    input  wire logic [DATA_W-1:0] data1,
    output logic                   room,
    output logic                   dout_valid,
    input  wire logic              dout_ready,
    output logic [DATA_W-1:0]      dout
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pop;
    logic [PW-1:0]     wr_ptr_1;

    assign room       = count_reg <= CNT_W'(DEPTH - 2);
    assign dout_valid = count_reg != '0;
    assign dout       = mem_reg[rd_ptr_reg];
    assign pop        = dout_valid && dout_ready;
    assign wr_ptr_1   = wr_ptr_reg + PW'(1);
    assign count_next = count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push0) + PW'(push1);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            mem_reg[wr_ptr_reg] <= data0;
        end
        if (push1)
        begin
            mem_reg[wr_ptr_1] <= data1;
        end
    end

endmodule

`default_nettype wire

// ===== sim/size_category_code_packer_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_category_code_packer_check
// Watches the coef and stream requests of the packer, predicts each packed
// word from the accepted coefficients and compares every field in order.
// ----------------------------------------------------------------------------

module size_category_code_packer_check #(
    parameter int WORD_BITS = sccp_pkg::DEFAULT_WORD_BITS,
    parameter int VB_W      = $clog2(WORD_BITS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          coef_valid,
    input  logic                          coef_ready,
    input  logic [sccp_pkg::VALUE_W-1:0]  coef_value,
    input  logic                          coef_last,
    input  logic                          stream_valid,
    input  logic                          stream_ready,
    input  logic [WORD_BITS-1:0]          stream_word,
    input  logic [VB_W-1:0]               stream_valid_bits,
    input  logic                          stream_final_word,
    output int                            errors,
    output int                            pending
);

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [VB_W-1:0]      valid_bits;
        logic                 final_word;
    } packed_word_t;

    localparam logic [6:0] DC_PREFIX [10] = '{
        7'd0, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd14, 7'd30, 7'd62, 7'd126
    };
    localparam int DC_PREFIX_LEN [10] = '{2, 3, 3, 3, 3, 3, 4, 5, 6, 7};

    packed_word_t expected_words [$];
    logic [63:0]  held_bits  = '0;
    int           held_count = 0;
    int           mismatch_count = 0;

    assign errors = mismatch_count;

    function automatic logic [63:0] low_ones(input int n);
        return (64'd1 << n) - 64'd1;
    endfunction

    task automatic pack_coefficient(input logic [sccp_pkg::VALUE_W-1:0] raw,
                                    input logic is_last);
        int          v;
        int          mag;
        int          size;
        int          len;
        int          space;
        int          rest;
        logic [63:0] code;
        logic [63:0] w;
        v = int'($signed(raw));
        if (v < -511)
            v = -511;
        mag  = (v < 0) ? -v : v;
        size = 0;
        while ((mag >> size) != 0)
            size++;
        code = (64'(DC_PREFIX[size]) << size)
             | ((v >= 0) ? 64'(mag) : (~64'(mag) & low_ones(size)));
        len   = DC_PREFIX_LEN[size] + size;
        space = WORD_BITS - held_count;
        if (len >= space)
        begin
            rest = len - space;
            w = ((held_bits << space) | (code >> rest)) & low_ones(WORD_BITS);
            held_bits  = code & low_ones(rest);
            held_count = rest;
            expected_words.push_back('{w[WORD_BITS-1:0], VB_W'(WORD_BITS),
                                       is_last && (rest == 0)});
        end
        else
        begin
            held_bits  = ((held_bits << len) | code) & low_ones(WORD_BITS);
            held_count += len;
        end
        if (is_last)
        begin
            if (held_count != 0)
                expected_words.push_back('{WORD_BITS'(held_bits & low_ones(held_count)),
                                           VB_W'(held_count), 1'b1});
            held_bits  = '0;
            held_count = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packed_word_t oldest;
        if (!rst_n)
        begin
            expected_words.delete();
            held_bits  = '0;
            held_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (coef_valid && coef_ready)
                pack_coefficient(coef_value, coef_last);
            if (stream_valid && stream_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word %h valid_bits %0d final_word %0b",
                           stream_word, stream_valid_bits, stream_final_word);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_words.pop_front();
                    if (stream_word !== oldest.word)
                    begin
                        $error("word: expected %h, actual %h", oldest.word, stream_word);
                        mismatch_count++;
                    end
                    if (stream_valid_bits !== oldest.valid_bits)
                    begin
                        $error("valid_bits: expected %0d, actual %0d",
                               oldest.valid_bits, stream_valid_bits);
                        mismatch_count++;
                    end
                    if (stream_final_word !== oldest.final_word)
                    begin
                        $error("final_word: expected %0b, actual %0b",
                               oldest.final_word, stream_final_word);
                        mismatch_count++;
                    end
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

// ===== sim/size_category_code_packer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_category_code_packer_tb
// Drives coefficient streams into the packer under several idle and stall
// mixes, directed corner cases first, then random streams; the checker
// predicts and compares every packed word.
// ----------------------------------------------------------------------------

module size_category_code_packer_tb;

    localparam int WORD_BITS      = sccp_pkg::DEFAULT_WORD_BITS;
    localparam int VALUE_W        = sccp_pkg::VALUE_W;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int PHASE_ITEMS    = 375;
    localparam int NUM_PHASES     = 4;
    localparam int SRC_IDLE [NUM_PHASES]   = '{0, 74, 0, 10};
    localparam int SINK_STALL [NUM_PHASES] = '{0, 0, 74, 10};
    localparam int SWEEP [20] = '{
        0, 1, -1, 2, -3, 4, -7, 8, -15, 16, -31, 32, -63, 64, -127, 128,
        -255, 256, -512, 511
    };

    logic clk;
    logic rst_n;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   cycle_count    = 0;
    int   mismatches;
    int   pending;

    sccp_in_if                           coef_if ();
    sccp_out_if #(.WORD_BITS(WORD_BITS)) stream_if ();

    size_category_code_packer #(.WORD_BITS(WORD_BITS)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .coef   (coef_if),
        .stream (stream_if)
    );

    size_category_code_packer_check #(.WORD_BITS(WORD_BITS)) u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .coef_valid        (coef_if.valid),
        .coef_ready        (coef_if.ready),
        .coef_value        (coef_if.value),
        .coef_last         (coef_if.last),
        .stream_valid      (stream_if.valid),
        .stream_ready      (stream_if.ready),
        .stream_word       (stream_if.word),
        .stream_valid_bits (stream_if.valid_bits),
        .stream_final_word (stream_if.final_word),
        .errors            (mismatches),
        .pending           (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        stream_if.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // hold the request until accepted; valid stays high into the next request unless an idle cycle is drawn
    task automatic send_coef(input logic [VALUE_W-1:0] v, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            coef_if.valid <= 1'b0;
            @(posedge clk);
        end
        coef_if.valid <= 1'b1;
        coef_if.value <= v;
        coef_if.last  <= is_last;
        do
            @(posedge clk);
        while (!coef_if.ready);
    endtask

    function automatic logic [VALUE_W-1:0] random_coefficient();
        int size;
        int mag;
        if ($urandom_range(1) == 1)
            return VALUE_W'($urandom_range(1023));
        size = $urandom_range(9);
        mag  = (size == 0) ? 0 : (1 << (size - 1)) + $urandom_range((1 << (size - 1)) - 1);
        return ($urandom_range(1) == 1) ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    initial
    begin
        coef_if.valid   <= 1'b0;
        coef_if.value   <= '0;
        coef_if.last    <= 1'b0;
        rst_n           <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SWEEP[i])
            send_coef(VALUE_W'(SWEEP[i]), i == 19);
        send_coef(10'd511, 1'b0);
        send_coef(10'd511, 1'b0);
        send_coef(10'd511, 1'b0);
        send_coef(VALUE_W'(-511), 1'b1);
        send_coef(10'd0, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            src_idle_pct   = SRC_IDLE[p];
            sink_stall_pct = SINK_STALL[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_coef(random_coefficient(), $urandom_range(11) == 0);
            send_coef(random_coefficient(), 1'b1);
        end
        coef_if.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/sccp_pkg.sv
sv/sccp_if.sv
sv/sccp_encoder.sv
sv/sccp_packer.sv
sv/sccp_res_fifo.sv
sv/size_category_code_packer.sv
sim/size_category_code_packer_check.sv
sim/size_category_code_packer_tb.sv
